/* src/hvt_pkg.sv */
package hvt_pkg;

  // accumulator geometry
  localparam int SECTORS    = 4;
  localparam int THETA_BINS = 16;
  localparam int PHI_BINS   = 128;
  localparam int RHO_BINS   = 128;
  localparam int COUNT_BITS = 16;

  localparam int SEC_W      = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int TH_W       = $clog2(THETA_BINS);
  localparam int PHI_W      = $clog2(PHI_BINS);
  localparam int RHO_W      = $clog2(RHO_BINS);
  localparam int STORE_SIZE = SECTORS * THETA_BINS * PHI_BINS * RHO_BINS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int LOOP_MAX   = (PHI_BINS > THETA_BINS) ?
                              ((PHI_BINS > SECTORS) ? PHI_BINS : SECTORS) :
                              ((THETA_BINS > SECTORS) ? THETA_BINS : SECTORS);
  localparam int CNT_W      = $clog2(LOOP_MAX);
  localparam int VOTE_W     = $clog2(PHI_BINS + 1);
  localparam int TH_N       = 2 * THETA_BINS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // word layout
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;

  // command codes (in_tuser)
  localparam logic [1:0] CMD_VOTE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // result kinds
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_VOTE = 2'd1;
  localparam logic [1:0] RES_READ = 2'd2;

  // register indexes
  localparam logic [1:0] REG_RHO_MIN  = 2'd0;
  localparam logic [1:0] REG_RHO_MAX  = 2'd1;
  localparam logic [1:0] REG_RHO_STEP = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              square;
    logic              sum;
    logic              sec_mul;
    logic              sec_acc;
    logic              th_mul;
    logic              th_acc;
    logic              phi_issue;
    logic              rd_issue;
    logic              rd_cap;
    logic              clr_wr;
    logic              res_load;
    logic [1:0]        res_kind;
    logic [CNT_W-1:0]  k;
    logic [ADDR_W-1:0] clr_addr;
  } hvt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } hvt_sts_t;

  // constant trig tables, Q1.15
  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] s;
  } trig_t;

  typedef logic [PHI_BINS-1:0][15:0]   phi_tab_t;
  typedef logic [THETA_BINS-1:0][15:0] th_tab_t;
  typedef logic [THETA_BINS-1:0][29:0] th_sq_tab_t;
  typedef logic [SECTORS-1:0][15:0]    sec_tab_t;
  typedef logic [SECTORS-1:0]          sec_hb_t;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1073741824;

  function automatic logic signed [15:0] to_q15(longint v);
    longint r;
    r = (v < 0) ? 64'sd0 : v;
    r = (r + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    return 16'(r);
  endfunction

  // taylor series on the folded angle, then quadrant placement
  function automatic trig_t trig_core(longint unsigned u, logic fold, int q);
    longint unsigned u2;
    longint unsigned term;
    longint          ss;
    longint          sc;
    logic signed [15:0] cu;
    logic signed [15:0] su;
    logic signed [15:0] cl;
    logic signed [15:0] sl;
    trig_t t;
    u2   = (u * u) >> 30;
    term = u;
    ss   = longint'(u);
    term = ((term * u2) >> 30) / 6;   ss = ss - longint'(term);
    term = ((term * u2) >> 30) / 20;  ss = ss + longint'(term);
    term = ((term * u2) >> 30) / 42;  ss = ss - longint'(term);
    term = ((term * u2) >> 30) / 72;  ss = ss + longint'(term);
    term = ((term * u2) >> 30) / 110; ss = ss - longint'(term);
    term = ((term * u2) >> 30) / 156; ss = ss + longint'(term);
    term = 64'(ONE_Q30);
    sc   = ONE_Q30;
    term = ((term * u2) >> 30) / 2;   sc = sc - longint'(term);
    term = ((term * u2) >> 30) / 12;  sc = sc + longint'(term);
    term = ((term * u2) >> 30) / 30;  sc = sc - longint'(term);
    term = ((term * u2) >> 30) / 56;  sc = sc + longint'(term);
    term = ((term * u2) >> 30) / 90;  sc = sc - longint'(term);
    term = ((term * u2) >> 30) / 132; sc = sc + longint'(term);
    cu = to_q15(sc);
    su = to_q15(ss);
    cl = fold ? su : cu;
    sl = fold ? cu : su;
    case (q)
      0: begin t.c = cl;  t.s = sl;  end
      1: begin t.c = -sl; t.s = cl;  end
      2: begin t.c = -cl; t.s = -sl; end
      default: begin t.c = sl; t.s = -cl; end
    endcase
    return t;
  endfunction

  function automatic trig_t phi_trig(int i);
    int four;
    int q;
    int r;
    logic fold;
    longint unsigned u;
    four = 4 * i;
    q    = four / PHI_BINS;
    r    = four % PHI_BINS;
    fold = (2 * r > PHI_BINS);
    if (fold) r = PHI_BINS - r;
    u = (HALF_PI_Q30 * 64'(r)) / PHI_BINS;
    return trig_core(u, fold, q);
  endfunction

  function automatic trig_t th_trig(int i);
    int four;
    int q;
    int r;
    logic fold;
    longint unsigned u;
    four = 4 * i;
    q    = four / TH_N;
    r    = four % TH_N;
    fold = (2 * r > TH_N);
    if (fold) r = TH_N - r;
    u = (HALF_PI_Q30 * 64'(r)) / TH_N;
    return trig_core(u, fold, q);
  endfunction

  function automatic trig_t sec_trig(int i);
    int four;
    int q;
    int r;
    logic fold;
    longint unsigned u;
    four = 4 * i;
    q    = four / SECTORS;
    r    = four % SECTORS;
    fold = (2 * r > SECTORS);
    if (fold) r = SECTORS - r;
    u = (HALF_PI_Q30 * 64'(r)) / SECTORS;
    return trig_core(u, fold, q);
  endfunction

  function automatic phi_tab_t build_phi_cos();
    phi_tab_t t;
    trig_t    v;
    for (int i = 0; i < PHI_BINS; i++) begin
      v    = phi_trig(i);
      t[i] = v.c;
    end
    return t;
  endfunction

  function automatic phi_tab_t build_phi_sin();
    phi_tab_t t;
    trig_t    v;
    for (int i = 0; i < PHI_BINS; i++) begin
      v    = phi_trig(i);
      t[i] = v.s;
    end
    return t;
  endfunction

  function automatic th_tab_t build_th_cos();
    th_tab_t t;
    trig_t   v;
    for (int i = 0; i < THETA_BINS; i++) begin
      v    = th_trig(i);
      t[i] = v.c;
    end
    return t;
  endfunction

  function automatic th_sq_tab_t build_th_sq();
    th_sq_tab_t t;
    trig_t      v;
    int         cc;
    for (int i = 0; i < THETA_BINS; i++) begin
      v    = th_trig(i);
      cc   = int'(v.c) * int'(v.c);
      t[i] = 30'(cc);
    end
    return t;
  endfunction

  function automatic sec_tab_t build_sec_cos();
    sec_tab_t t;
    trig_t    v;
    for (int i = 0; i < SECTORS; i++) begin
      v    = sec_trig(i);
      t[i] = v.c;
    end
    return t;
  endfunction

  function automatic sec_tab_t build_sec_sin();
    sec_tab_t t;
    trig_t    v;
    for (int i = 0; i < SECTORS; i++) begin
      v    = sec_trig(i);
      t[i] = v.s;
    end
    return t;
  endfunction

  // boundary lies in the lower half plane
  function automatic sec_hb_t build_sec_hb();
    sec_hb_t t;
    trig_t   v;
    for (int i = 0; i < SECTORS; i++) begin
      v    = sec_trig(i);
      t[i] = (v.s < 0) || ((v.s == 0) && (v.c < 0));
    end
    return t;
  endfunction

  localparam phi_tab_t   PHI_COS = build_phi_cos();
  localparam phi_tab_t   PHI_SIN = build_phi_sin();
  localparam th_tab_t    TH_COS  = build_th_cos();
  localparam th_sq_tab_t TH_SQ   = build_th_sq();
  localparam sec_tab_t   SEC_COS = build_sec_cos();
  localparam sec_tab_t   SEC_SIN = build_sec_sin();
  localparam sec_hb_t    SEC_HB  = build_sec_hb();

endpackage

/* src/hvt_ctrl.sv */
module hvt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        command,
  input  hvt_pkg::hvt_sts_t sts,
  output hvt_pkg::hvt_cmd_t cmd
);
  import hvt_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CLEAR   = 4'd1;
  localparam logic [3:0] ST_SQ      = 4'd2;
  localparam logic [3:0] ST_SUM     = 4'd3;
  localparam logic [3:0] ST_SEC_MUL = 4'd4;
  localparam logic [3:0] ST_SEC_CMP = 4'd5;
  localparam logic [3:0] ST_TH_MUL  = 4'd6;
  localparam logic [3:0] ST_TH_CMP  = 4'd7;
  localparam logic [3:0] ST_PHI     = 4'd8;
  localparam logic [3:0] ST_DRAIN   = 4'd9;
  localparam logic [3:0] ST_RD      = 4'd10;
  localparam logic [3:0] ST_RD_CAP  = 4'd11;
  localparam logic [3:0] ST_DONE    = 4'd12;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic              clr_cmd_r, clr_cmd_nxt;

  // sequencing
  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    addr_nxt     = addr_r;
    kind_nxt     = kind_r;
    clr_cmd_nxt  = clr_cmd_r;
    cmd          = '0;
    cmd.k        = k_r;
    cmd.clr_addr = addr_r;
    cmd.res_kind = kind_r;
    in_tready    = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          unique case (command)
            CMD_VOTE: state_nxt = ST_SQ;
            CMD_READ: state_nxt = ST_RD;
            CMD_CLEAR: begin
              addr_nxt    = '0;
              clr_cmd_nxt = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            default: begin
              kind_nxt  = RES_ZERO;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        addr_nxt   = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt    = '0;
          clr_cmd_nxt = 1'b0;
          kind_nxt    = RES_ZERO;
          state_nxt   = clr_cmd_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        k_nxt     = CNT_W'(1);
        state_nxt = (SECTORS > 1) ? ST_SEC_MUL : ST_TH_MUL;
      end
      ST_SEC_MUL: begin
        cmd.sec_mul = 1'b1;
        state_nxt   = ST_SEC_CMP;
      end
      ST_SEC_CMP: begin
        cmd.sec_acc = 1'b1;
        if (k_r == CNT_W'(SECTORS - 1)) begin
          k_nxt     = CNT_W'(1);
          state_nxt = ST_TH_MUL;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_SEC_MUL;
        end
      end
      ST_TH_MUL: begin
        cmd.th_mul = 1'b1;
        state_nxt  = ST_TH_CMP;
      end
      ST_TH_CMP: begin
        cmd.th_acc = 1'b1;
        if (k_r == CNT_W'(THETA_BINS - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_PHI;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_TH_MUL;
        end
      end
      ST_PHI: begin
        cmd.phi_issue = 1'b1;
        if (k_r == CNT_W'(PHI_BINS - 1)) begin
          k_nxt     = '0;
          kind_nxt  = RES_VOTE;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = ST_DONE;
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        cmd.rd_cap = 1'b1;
        kind_nxt   = RES_READ;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers, clearing sweep starts at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      k_r       <= '0;
      addr_r    <= '0;
      kind_r    <= RES_ZERO;
      clr_cmd_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      addr_r    <= addr_nxt;
      kind_r    <= kind_nxt;
      clr_cmd_r <= clr_cmd_nxt;
    end
  end

endmodule

/* src/hvt_datapath.sv */
module hvt_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [17:0]       hit_x,
  input  logic signed [17:0]       hit_y,
  input  logic signed [17:0]       hit_z,
  input  logic [1:0]               read_sector,
  input  logic [3:0]               read_theta,
  input  logic [6:0]               read_phi,
  input  logic [6:0]               read_rho,
  input  logic [17:0]              rho_min,
  input  logic [17:0]              rho_max,
  input  logic [23:0]              rho_step,
  input  hvt_pkg::hvt_cmd_t        cmd,
  output hvt_pkg::hvt_sts_t        sts,
  input  logic                     out_tready,
  output logic                     out_tvalid,
  output logic [31:0]              out_tdata
);
  import hvt_pkg::*;

  localparam int DIV_W = 58 + RHO_W + 1;

  // captured word
  logic signed [17:0] x_r, y_r, z_r;
  logic [1:0]         rs_r;
  logic [3:0]         rt_r;
  logic [6:0]         rp_r, rr_r;

  // hit geometry
  logic signed [35:0] x_sq, y_sq, z_sq;
  logic [34:0]        x2_r, y2_r, z2_r;
  logic [35:0]        rxy_r, r3_r;
  logic [49:0]        num;

  // sector search
  logic [SEC_W-1:0]   ksec;
  logic signed [15:0] bx, by;
  logic signed [33:0] sp1_r, sp2_r;
  logic signed [34:0] sdiff;
  logic               ha, hb, ge, xy_nz;
  logic [SEC_W-1:0]   sec_r;

  // theta search
  logic [TH_W-1:0]    kth;
  logic [29:0]        c2;
  logic signed [15:0] tc;
  logic [47:0]        tm_lo_r, tm_hi_r;
  logic [65:0]        rhs, lhs;
  logic               zpos, le;
  logic [TH_W-1:0]    th_r;

  // phi pipeline
  logic [PHI_W-1:0]   pidx;
  logic signed [15:0] pc, ps;
  logic               p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  logic [PHI_W-1:0]   p1_i_r, p2_i_r, p3_i_r, p4_i_r;
  logic signed [33:0] px_r, py_r;
  logic signed [34:0] d_r;
  logic [33:0]        ud;
  logic [23:0]        step_eff;
  logic [51:0]        lo_r, hi_r, num52;
  logic [57:0]        den_r, den4_r;
  logic [DIV_W-1:0]   n_r;

  logic               dv_r  [RHO_W+1];
  logic [DIV_W-1:0]   rem_r [RHO_W+1];
  logic [DIV_W-1:0]   dd_r  [RHO_W+1];
  logic [RHO_W-1:0]   q_r   [RHO_W+1];
  logic [PHI_W-1:0]   di_r  [RHO_W+1];
  logic               dv_any;

  logic               a_v_r, w_v_r;
  logic [ADDR_W-1:0]  vaddr, addr_r, w_addr_r;

  // counter store
  logic [COUNT_BITS-1:0] mem [STORE_SIZE];
  logic [COUNT_BITS-1:0] mem_q_r, wdata;
  logic [ADDR_W-1:0]     raddr, waddr, rd_addr;
  logic                  we, rd_ok, bump;
  logic [VOTE_W-1:0]     votes_r;

  // result
  logic               out_v_r;
  logic [15:0]        count_r, count_o_r;
  logic [7:0]         votes_o_r;
  logic [1:0]         sec_o_r;
  logic [3:0]         th_o_r;

  assign x_sq  = x_r * x_r;
  assign y_sq  = y_r * y_r;
  assign z_sq  = z_r * z_r;
  assign num   = {rxy_r, 14'b0};
  assign num52 = {2'b0, num};

  // sector boundary compare
  assign ksec  = cmd.k[SEC_W-1:0];
  assign bx    = $signed(SEC_COS[ksec]);
  assign by    = $signed(SEC_SIN[ksec]);
  assign sdiff = {sp1_r[33], sp1_r} - {sp2_r[33], sp2_r};
  assign ha    = (y_r < 0) || ((y_r == 0) && (x_r < 0));
  assign hb    = SEC_HB[ksec];
  assign ge    = (ha != hb) ? (ha & ~hb) : (sdiff >= 0);
  assign xy_nz = (x_r != 0) || (y_r != 0);

  // theta boundary compare, z^2 * 2^30 against c^2 * r^2
  assign kth  = cmd.k[TH_W-1:0];
  assign c2   = TH_SQ[kth];
  assign tc   = $signed(TH_COS[kth]);
  assign rhs  = {tm_hi_r, 18'b0} + {18'b0, tm_lo_r};
  assign lhs  = {1'b0, z2_r, 30'b0};
  assign zpos = (z_r > 0);
  always_comb begin
    if (!zpos && (tc >= 0))     le = 1'b1;
    else if (zpos && (tc <= 0)) le = 1'b0;
    else if (zpos)              le = (lhs <= rhs);
    else                        le = (lhs >= rhs);
  end

  // hit setup registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r  <= hit_x;
      y_r  <= hit_y;
      z_r  <= hit_z;
      rs_r <= read_sector;
      rt_r <= read_theta;
      rp_r <= read_phi;
      rr_r <= read_rho;
    end
    if (cmd.square) begin
      x2_r <= x_sq[34:0];
      y2_r <= y_sq[34:0];
      z2_r <= z_sq[34:0];
    end
    if (cmd.sum) begin
      rxy_r <= {1'b0, x2_r} + {1'b0, y2_r};
      r3_r  <= {1'b0, x2_r} + {1'b0, y2_r} + {1'b0, z2_r};
    end
    if (cmd.sec_mul) begin
      sp1_r <= bx * y_r;
      sp2_r <= by * x_r;
    end
    if (cmd.th_mul) begin
      tm_lo_r <= 48'(c2) * 48'(r3_r[17:0]);
      tm_hi_r <= 48'(c2) * 48'(r3_r[35:18]);
    end
  end

  // sector, theta and vote tallies
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sec_r   <= '0;
      th_r    <= '0;
      votes_r <= '0;
    end else begin
      if (cmd.sec_acc && xy_nz && ge) sec_r <= sec_r + 1'b1;
      if (cmd.th_acc && (r3_r != 0) && le) th_r <= th_r + 1'b1;
      if (bump) votes_r <= votes_r + 1'b1;
    end
  end

  // phi table lookup and front stages
  assign pidx     = cmd.k[PHI_W-1:0];
  assign pc       = $signed(PHI_COS[pidx]);
  assign ps       = $signed(PHI_SIN[pidx]);
  assign ud       = d_r[33:0];
  assign step_eff = (rho_step == 24'd0) ? 24'd1 : rho_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.phi_issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r && (d_r > 0);
      p4_v_r <= p3_v_r && (num52 > lo_r) && (num52 <= hi_r);
    end
  end

  always_ff @(posedge clk) begin
    p1_i_r <= pidx;
    px_r   <= pc * x_r;
    py_r   <= ps * y_r;
    p2_i_r <= p1_i_r;
    d_r    <= {px_r[33], px_r} + {py_r[33], py_r};
    p3_i_r <= p2_i_r;
    lo_r   <= 52'(rho_min) * 52'(ud);
    hi_r   <= 52'(rho_max) * 52'(ud);
    den_r  <= 58'(ud) * 58'(step_eff);
    p4_i_r <= p3_i_r;
    n_r    <= DIV_W'({num52 - lo_r, 8'b0});
    den4_r <= den_r;
  end

  // range check against the top rho bin, then one quotient bit per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= p4_v_r && (n_r < (DIV_W'(den4_r) << RHO_W));
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= n_r;
    dd_r[0]  <= DIV_W'(den4_r);
    q_r[0]   <= '0;
    di_r[0]  <= p4_i_r;
  end

  for (genvar s = 0; s < RHO_W; s++) begin : g_div
    localparam int J = RHO_W - 1 - s;
    logic [DIV_W-1:0] sh;
    logic             take;
    assign sh   = dd_r[s] << J;
    assign take = (rem_r[s] >= sh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s+1] <= 1'b0;
      end else begin
        dv_r[s+1] <= dv_r[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s+1] <= take ? (rem_r[s] - sh) : rem_r[s];
      q_r[s+1]   <= q_r[s] | (take ? (RHO_W'(1) << J) : '0);
      dd_r[s+1]  <= dd_r[s];
      di_r[s+1]  <= di_r[s];
    end
  end

  always_comb begin
    dv_any = 1'b0;
    for (int s = 0; s <= RHO_W; s++) dv_any = dv_any | dv_r[s];
  end

  // counter address of the vote
  assign vaddr = ADDR_W'((((32'(sec_r) * THETA_BINS + 32'(th_r)) * PHI_BINS
                 + 32'(di_r[RHO_W])) * RHO_BINS) + 32'(q_r[RHO_W]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      w_v_r <= 1'b0;
    end else begin
      a_v_r <= dv_r[RHO_W] && (32'(q_r[RHO_W]) < RHO_BINS);
      w_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= vaddr;
    w_addr_r <= addr_r;
  end

  // read-modify-write on the counter store
  assign rd_ok   = (32'(rs_r) < SECTORS) && (32'(rt_r) < THETA_BINS) &&
                   (32'(rp_r) < PHI_BINS) && (32'(rr_r) < RHO_BINS);
  assign rd_addr = ADDR_W'((((32'(rs_r) * THETA_BINS + 32'(rt_r)) * PHI_BINS
                   + 32'(rp_r)) * RHO_BINS) + 32'(rr_r));
  assign raddr   = cmd.rd_issue ? rd_addr : addr_r;
  assign bump    = w_v_r && (mem_q_r != COUNT_MAX);
  assign we      = cmd.clr_wr || bump;
  assign waddr   = cmd.clr_wr ? cmd.clr_addr : w_addr_r;
  assign wdata   = cmd.clr_wr ? '0 : (mem_q_r + 1'b1);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_q_r <= mem[raddr];
  end

  // read result capture
  always_ff @(posedge clk) begin
    if (cmd.rd_cap) begin
      if (!rd_ok)                         count_r <= '0;
      else if (32'(mem_q_r) > 32'hFFFF)   count_r <= 16'hFFFF;
      else                                count_r <= 16'(mem_q_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      count_o_r <= '0;
      votes_o_r <= '0;
      sec_o_r   <= '0;
      th_o_r    <= '0;
      case (cmd.res_kind)
        RES_VOTE: begin
          votes_o_r <= (32'(votes_r) > 32'd255) ? 8'hFF : 8'(votes_r);
          sec_o_r   <= 2'(sec_r);
          th_o_r    <= 4'(th_r);
        end
        RES_READ: count_o_r <= count_r;
        default: ;
      endcase
    end
  end

  assign out_tvalid    = out_v_r;
  assign out_tdata     = {2'b0, th_o_r, sec_o_r, votes_o_r, count_o_r};
  assign sts.pipe_busy = p1_v_r | p2_v_r | p3_v_r | p4_v_r | dv_any | a_v_r | w_v_r;
  assign sts.out_free  = !out_v_r || out_tready;

endmodule

/* src/hough_track_vote_accumulator.sv */
// channel   dir  handshake                 payload
// in_       in   in_tvalid / in_tready     tuser command, tdata hit and read address
// out_      out  out_tvalid / out_tready   tdata count, votes_cast, hit_sector, hit_theta
// cfg       in   psel / penable / pready   rho_min, rho_max, rho_step at 0x0, 0x4, 0x8
//
// A vote steps through the square and sum states, the sector and theta boundary
// searches and the phi loop, and no new word is accepted until its result is loaded;
// the phi loop issues one bin per cycle into a pipeline ending in one
// read-modify-write per cycle on the counter RAM.
// A read issues, then captures; a clear sweeps all 1048576 counters, one a cycle.
// After reset the same sweep runs with in_tready low.
// A result waits in the output register and the next word is accepted meanwhile.
module hough_track_vote_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  // in: tuser [1:0] command
  //     tdata [17:0] hit_x, [35:18] hit_y, [53:36] hit_z, [55:54] read_sector,
  //           [59:56] read_theta, [66:60] read_phi, [73:67] read_rho
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic [1:0]  in_tuser,
  // out: tdata [15:0] count, [23:16] votes_cast, [25:24] hit_sector, [29:26] hit_theta
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hvt_pkg::*;

  logic [17:0] rho_min_r, rho_max_r;
  logic [23:0] rho_step_r;
  logic [1:0]  reg_idx;
  logic        wr_en;
  hvt_cmd_t    cmd;
  hvt_sts_t    sts;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_min_r  <= 18'd500;
      rho_max_r  <= 18'd100000;
      rho_step_r <= 24'd199000;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RHO_MIN:  rho_min_r  <= pwdata[17:0];
        REG_RHO_MAX:  rho_max_r  <= pwdata[17:0];
        REG_RHO_STEP: rho_step_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RHO_MIN:  prdata = {14'b0, rho_min_r};
      REG_RHO_MAX:  prdata = {14'b0, rho_max_r};
      REG_RHO_STEP: prdata = {8'b0, rho_step_r};
      default:      prdata = '0;
    endcase
  end

  hvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .command   (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  hvt_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .hit_x       ($signed(in_tdata[17:0])),
    .hit_y       ($signed(in_tdata[35:18])),
    .hit_z       ($signed(in_tdata[53:36])),
    .read_sector (in_tdata[55:54]),
    .read_theta  (in_tdata[59:56]),
    .read_phi    (in_tdata[66:60]),
    .read_rho    (in_tdata[73:67]),
    .rho_min     (rho_min_r),
    .rho_max     (rho_max_r),
    .rho_step    (rho_step_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

endmodule
